### rtl/core/triangle_span_coverage_unit_assert.svh
// Assertion macros used by the checker file of the span coverage unit.
`ifndef TRIANGLE_SPAN_COVERAGE_UNIT_ASSERT_SVH
`define TRIANGLE_SPAN_COVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tsc_pkg.sv
// Types, widths and constants of the triangle span coverage unit.
package tsc_pkg;

	localparam int COORD_BITS = 12;
	localparam int SPAN_WIDTH = 64;
	localparam int MASK_BITS  = 64;
	localparam int COLOR_BITS = 16;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int EDGE_W = PROD_W + 2;
	localparam int SUM_W  = EDGE_W + 1;
	localparam int LANE_W = (SPAN_WIDTH > 1) ? $clog2(SPAN_WIDTH) : 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [EDGE_W-1:0]     edge_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic [COLOR_BITS-1:0]        color_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vert_a_x;
		logic signed [COORD_BITS-1:0] vert_a_y;
		logic signed [COORD_BITS-1:0] vert_b_x;
		logic signed [COORD_BITS-1:0] vert_b_y;
		logic signed [COORD_BITS-1:0] vert_c_x;
		logic signed [COORD_BITS-1:0] vert_c_y;
		logic signed [COORD_BITS-1:0] row_y;
		logic signed [COORD_BITS-1:0] span_x;
		logic [COLOR_BITS-1:0]        pixel_color;
	} tsc_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_row_y;
		logic signed [COORD_BITS-1:0] out_span_x;
		logic [MASK_BITS-1:0]         coverage_mask;
		logic [COLOR_BITS-1:0]        out_color;
		logic                         zero_area;
	} tsc_result_t;

	// Fields carried unchanged from item to result.
	typedef struct packed {
		coord_t row_y;
		coord_t span_x;
		color_t color;
	} tsc_echo_t;

	// Triangle setup handed from the front end to every lane.
	typedef struct packed {
		edge_t     area;
		edge_t     s0;
		edge_t     t0;
		diff_t     ey;
		diff_t     dy;
		tsc_echo_t echo;
	} tsc_setup_t;

endpackage

### rtl/core/tsc_front.sv
// Triangle setup pipeline: edge vectors, products, doubled area and first-pixel edge values.
module tsc_front import tsc_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  tsc_item_t  item,
	output tsc_setup_t setup_s3
);

	diff_t     dx_s1, dy_s1, ex_s1, ey_s1, qx_s1, qy_s1;
	tsc_echo_t echo_s1;

	prod_t     p_dxey_s2, p_dyex_s2, p_qxey_s2, p_qyex_s2, p_dxqy_s2, p_dyqx_s2;
	diff_t     ey_s2, dy_s2;
	tsc_echo_t echo_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DIFF_W'(item.vert_b_x) - DIFF_W'(item.vert_a_x);
			dy_s1   <= DIFF_W'(item.vert_b_y) - DIFF_W'(item.vert_a_y);
			ex_s1   <= DIFF_W'(item.vert_c_x) - DIFF_W'(item.vert_a_x);
			ey_s1   <= DIFF_W'(item.vert_c_y) - DIFF_W'(item.vert_a_y);
			qx_s1   <= DIFF_W'(item.span_x) - DIFF_W'(item.vert_a_x);
			qy_s1   <= DIFF_W'(item.row_y) - DIFF_W'(item.vert_a_y);
			echo_s1 <= '{row_y: item.row_y, span_x: item.span_x, color: item.pixel_color};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_dxey_s2 <= dx_s1 * ey_s1;
			p_dyex_s2 <= dy_s1 * ex_s1;
			p_qxey_s2 <= qx_s1 * ey_s1;
			p_qyex_s2 <= qy_s1 * ex_s1;
			p_dxqy_s2 <= dx_s1 * qy_s1;
			p_dyqx_s2 <= dy_s1 * qx_s1;
			ey_s2     <= ey_s1;
			dy_s2     <= dy_s1;
			echo_s2   <= echo_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			setup_s3.area <= EDGE_W'(p_dxey_s2) - EDGE_W'(p_dyex_s2);
			setup_s3.s0   <= EDGE_W'(p_qxey_s2) - EDGE_W'(p_qyex_s2);
			setup_s3.t0   <= EDGE_W'(p_dxqy_s2) - EDGE_W'(p_dyqx_s2);
			setup_s3.ey   <= ey_s2;
			setup_s3.dy   <= dy_s2;
			setup_s3.echo <= echo_s2;
		end
	end

endmodule

### rtl/core/tsc_lane.sv
// One pixel lane: steps the edge values to its pixel and runs the inside test.
module tsc_lane import tsc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [LANE_W-1:0] lane_idx,
	input  tsc_setup_t        setup,
	input  edge_t             area,
	input  logic              area_pos,
	output logic              hit_s5
);

	logic signed [LANE_W:0]        offs;
	logic signed [LANE_W+DIFF_W:0] step_s, step_t;
	edge_t                         s_s4, t_s4;
	sum_t                          st_sum;
	sum_t                          area_ext;
	logic                          in_tri;

	// Moving one pixel right adds ey to S and subtracts dy from T.
	assign offs   = signed'({1'b0, lane_idx});
	assign step_s = offs * setup.ey;
	assign step_t = offs * setup.dy;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= setup.s0 + EDGE_W'(step_s);
			t_s4 <= setup.t0 - EDGE_W'(step_t);
		end
	end

	assign st_sum   = sum_t'(s_s4) + sum_t'(t_s4);
	assign area_ext = sum_t'(area);

	always_comb begin
		if (area_pos) begin
			in_tri = !s_s4[EDGE_W-1] && !t_s4[EDGE_W-1] && (st_sum <= area_ext);
		end else begin
			in_tri = (s_s4 <= 0) && (t_s4 <= 0) && (st_sum >= area_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5 <= in_tri;
		end
	end

endmodule

### rtl/core/tsc_merge.sv
// Result stage: gathers lane hits into the coverage mask and holds the result item.
module tsc_merge import tsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_s5,
	input  logic [SPAN_WIDTH-1:0] hits_s5,
	input  logic                  zero_s5,
	input  tsc_echo_t             echo_s5,
	output tsc_result_t           result,
	output logic                  result_valid
);

	logic [MASK_BITS-1:0] mask;
	tsc_result_t          res_q;
	logic                 res_valid_q;

	// Drop every hit of a degenerate triangle; bits past the span stay clear.
	always_comb begin
		mask = '0;
		if (!zero_s5) begin
			mask[SPAN_WIDTH-1:0] = hits_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.out_row_y     <= echo_s5.row_y;
			res_q.out_span_x    <= echo_s5.span_x;
			res_q.coverage_mask <= mask;
			res_q.out_color     <= echo_s5.color;
			res_q.zero_area     <= zero_s5;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

### rtl/core/triangle_span_coverage_unit.sv
// Top level of the triangle span coverage unit.
// Takes one span item per cycle while not stalled and returns its coverage mask after
// three setup stages (edge vectors, six 13x13 products, doubled area and first-pixel edge
// values), one lane stage that steps the edge values across the span, one inside-test stage
// and the result register. All SPAN_WIDTH pixels are tested at once by their own lanes. The
// pipeline advances as a whole; it stalls only while a finished result waits to be taken, so
// item_ready follows result_ready combinationally when the result register is full.
module triangle_span_coverage_unit import tsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  tsc_item_t   item,
	output logic        result_valid,
	input  logic        result_ready,
	output tsc_result_t result
);

	logic                  advance;
	logic                  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	tsc_setup_t            setup_s3;
	edge_t                 area_s4;
	logic                  pos_s4, zero_s4, zero_s5;
	tsc_echo_t             echo_s4, echo_s5;
	logic [SPAN_WIDTH-1:0] hits_s5;

	assign advance    = !result_valid || result_ready;
	assign item_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	tsc_front u_front (
		.clk      (clk),
		.en       (advance),
		.item     (item),
		.setup_s3 (setup_s3)
	);

	// Shared per-item values for the lanes and the result stage.
	always_ff @(posedge clk) begin
		if (advance) begin
			area_s4 <= setup_s3.area;
			pos_s4  <= !setup_s3.area[EDGE_W-1];
			zero_s4 <= (setup_s3.area == '0);
			echo_s4 <= setup_s3.echo;
			zero_s5 <= zero_s4;
			echo_s5 <= echo_s4;
		end
	end

	for (genvar i = 0; i < SPAN_WIDTH; i++) begin : g_lane
		tsc_lane u_lane (
			.clk      (clk),
			.en       (advance),
			.lane_idx (LANE_W'(i)),
			.setup    (setup_s3),
			.area     (area_s4),
			.area_pos (pos_s4),
			.hit_s5   (hits_s5[i])
		);
	end

	tsc_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.valid_s5     (valid_s5),
		.hits_s5      (hits_s5),
		.zero_s5      (zero_s5),
		.echo_s5      (echo_s5),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

### rtl/core/tsc_checker.sv
// Port-level checker for the triangle span coverage unit, bound to the top level.
`include "triangle_span_coverage_unit_assert.svh"

module tsc_checker import tsc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input tsc_result_t result
);

	`TSC_ASSERT_NEXT(a_result_hold, clk, arst_n,
		result_valid && !result_ready, result_valid && $stable(result),
		"result item changed while stalled")
	`TSC_ASSERT_NOW(a_zero_area_empty, clk, arst_n,
		result_valid && result.zero_area, result.coverage_mask == '0,
		"degenerate triangle reported coverage")
	`TSC_ASSERT_NOW(a_ready_when_empty, clk, arst_n,
		!result_valid, item_ready,
		"item refused with empty result register")
	`TSC_ASSERT_NOW(a_ready_on_take, clk, arst_n,
		result_valid && result_ready, item_ready,
		"item refused while result is taken")

endmodule

bind triangle_span_coverage_unit tsc_checker u_tsc_checker (.*);

### test/tb_top.sv
// Self-checking testbench for the triangle span coverage unit: directed spans, then random ones.
module tb_top;
	import tsc_pkg::*;

	localparam int CMAX        = (1 << (COORD_BITS - 1)) - 1;
	localparam int CMIN        = -CMAX - 1;
	localparam int RANDOM_SPANS = 1950;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN       = 20;

	typedef struct {
		tsc_item_t   stim;
		bit          known;
		logic [63:0] mask;
		bit          zero;
	} span_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	tsc_item_t   span_item;
	logic        result_valid;
	logic        result_ready;
	tsc_result_t span_result;

	tsc_result_t pending_spans[$];
	span_row_t   span_table[$];
	int          mismatches;
	int          spans_sent;
	int          spans_returned;
	int          covered_spans;
	int          degenerate_spans;
	int          full_spans;
	int          cycles;
	bit          quiet;
	bit          long_hold_req;

	triangle_span_coverage_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (span_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (span_result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Exact signed edge products, no division: sign of S, T and D-S-T decides coverage.
	function automatic tsc_result_t span_coverage(tsc_item_t it);
		longint ax, ay, dx, dy, ex, ey, area, qx, qy, s, t;
		logic [63:0] mask;
		tsc_result_t r;
		ax = $signed(it.vert_a_x);
		ay = $signed(it.vert_a_y);
		dx = $signed(it.vert_b_x) - ax;
		dy = $signed(it.vert_b_y) - ay;
		ex = $signed(it.vert_c_x) - ax;
		ey = $signed(it.vert_c_y) - ay;
		area = dx * ey - dy * ex;
		mask = '0;
		if (area != 0) begin
			qy = $signed(it.row_y) - ay;
			for (int i = 0; i < SPAN_WIDTH && i < 64; i++) begin
				// pixel x is the exact integer, never wrapped to the coordinate range
				qx = $signed(it.span_x) + i - ax;
				s = qx * ey - qy * ex;
				t = dx * qy - dy * qx;
				if (area > 0)
					mask[i] = (s >= 0) && (t >= 0) && (s + t <= area);
				else
					mask[i] = (s <= 0) && (t <= 0) && (s + t >= area);
			end
		end
		r.out_row_y     = it.row_y;
		r.out_span_x    = it.span_x;
		r.coverage_mask = mask;
		r.out_color     = it.pixel_color;
		r.zero_area     = (area == 0);
		return r;
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > CMAX)
			return coord_t'(CMAX);
		if (v < CMIN)
			return coord_t'(CMIN);
		return coord_t'(v);
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic tsc_item_t random_span();
		tsc_item_t it;
		int mode, sx, ry, ax, ay, dx, dy, k, m, lo, hi;
		int vx[3];
		int vy[3];
		mode = $urandom_range(0, 99);
		it = '0;
		it.pixel_color = 16'($urandom());
		if (mode < 60) begin
			// small triangle around the span, most pixels near an edge
			sx = any_coord();
			ry = any_coord();
			it.span_x   = coord_t'(sx);
			it.row_y    = coord_t'(ry);
			it.vert_a_x = clamp_coord(sx + int'($urandom_range(0, 96)) - 16);
			it.vert_a_y = clamp_coord(ry + int'($urandom_range(0, 80)) - 40);
			it.vert_b_x = clamp_coord(sx + int'($urandom_range(0, 96)) - 16);
			it.vert_b_y = clamp_coord(ry + int'($urandom_range(0, 80)) - 40);
			it.vert_c_x = clamp_coord(sx + int'($urandom_range(0, 96)) - 16);
			it.vert_c_y = clamp_coord(ry + int'($urandom_range(0, 80)) - 40);
		end else if (mode < 72) begin
			// large triangle, span row inside its bounding box and span overlapping it in x
			for (int j = 0; j < 3; j++) begin
				vx[j] = any_coord();
				vy[j] = any_coord();
			end
			lo = vy[0] < vy[1] ? vy[0] : vy[1];
			lo = lo < vy[2] ? lo : vy[2];
			hi = vy[0] > vy[1] ? vy[0] : vy[1];
			hi = hi > vy[2] ? hi : vy[2];
			it.row_y = coord_t'(int'($urandom_range(0, hi - lo)) + lo);
			lo = vx[0] < vx[1] ? vx[0] : vx[1];
			lo = (lo < vx[2] ? lo : vx[2]) - 63;
			hi = vx[0] > vx[1] ? vx[0] : vx[1];
			hi = hi > vx[2] ? hi : vx[2];
			it.span_x   = clamp_coord(int'($urandom_range(0, hi - lo)) + lo);
			it.vert_a_x = coord_t'(vx[0]);
			it.vert_a_y = coord_t'(vy[0]);
			it.vert_b_x = coord_t'(vx[1]);
			it.vert_b_y = coord_t'(vy[1]);
			it.vert_c_x = coord_t'(vx[2]);
			it.vert_c_y = coord_t'(vy[2]);
		end else if (mode < 84) begin
			// collinear or coincident vertices
			ax = int'($urandom_range(0, 3800)) - 1900;
			ay = int'($urandom_range(0, 3800)) - 1900;
			dx = int'($urandom_range(0, 16)) - 8;
			dy = int'($urandom_range(0, 16)) - 8;
			k  = int'($urandom_range(0, 20)) - 10;
			m  = int'($urandom_range(0, 20)) - 10;
			it.vert_a_x = coord_t'(ax);
			it.vert_a_y = coord_t'(ay);
			it.vert_b_x = coord_t'(ax + k * dx);
			it.vert_b_y = coord_t'(ay + k * dy);
			it.vert_c_x = coord_t'(ax + m * dx);
			it.vert_c_y = coord_t'(ay + m * dy);
			it.row_y    = coord_t'(ay + int'($urandom_range(0, 20)) - 10);
			it.span_x   = coord_t'(ax - int'($urandom_range(0, 63)));
		end else begin
			it = tsc_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
		end
		return it;
	endfunction

	task automatic add_row(input int ax, ay, bx, by, cx, cy, row, span,
			input logic [15:0] color, input bit known, input logic [63:0] mask, input bit zero);
		span_row_t r;
		r.stim.vert_a_x    = coord_t'(ax);
		r.stim.vert_a_y    = coord_t'(ay);
		r.stim.vert_b_x    = coord_t'(bx);
		r.stim.vert_b_y    = coord_t'(by);
		r.stim.vert_c_x    = coord_t'(cx);
		r.stim.vert_c_y    = coord_t'(cy);
		r.stim.row_y       = coord_t'(row);
		r.stim.span_x      = coord_t'(span);
		r.stim.pixel_color = color;
		r.known            = known;
		r.mask             = mask;
		r.zero             = zero;
		span_table.push_back(r);
	endtask

	// Offer one item, hold it until taken, then queue what it must produce.
	task automatic send_span(input tsc_item_t it, input tsc_result_t want);
		item_valid <= 1'b1;
		span_item  <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		pending_spans.push_back(want);
		spans_sent++;
	endtask

	task automatic maybe_gap(input bit allowed);
		if (allowed && !quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want, got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 100)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		tsc_result_t want;
		if (arst_n && result_valid && result_ready) begin
			spans_returned++;
			if (pending_spans.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, expected nothing, got %h",
					$time, span_result);
			end else begin
				want = pending_spans.pop_front();
				check_field("out_row_y", want.out_row_y, span_result.out_row_y);
				check_field("out_span_x", want.out_span_x, span_result.out_span_x);
				check_field("coverage_mask", want.coverage_mask, span_result.coverage_mask);
				check_field("out_color", want.out_color, span_result.out_color);
				check_field("zero_area", want.zero_area, span_result.zero_area);
				if (want.zero_area)
					degenerate_spans++;
				if (want.coverage_mask != '0)
					covered_spans++;
				if (&want.coverage_mask)
					full_spans++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Result side: random stall bursts, one long hold-off on request.
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				result_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		tsc_item_t   it;
		tsc_result_t want;
		int          no_gap_left;
		cycles           = 0;
		mismatches       = 0;
		spans_sent       = 0;
		spans_returned   = 0;
		covered_spans    = 0;
		degenerate_spans = 0;
		full_spans       = 0;
		quiet            = 1'b0;
		long_hold_req    = 1'b0;
		no_gap_left      = 0;
		arst_n           = 1'b0;
		item_valid       = 1'b0;
		span_item        = '0;

		// coincident, collinear and flat triangles cover nothing
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 1, '0, 1);
		add_row(-2048, -2048, 0, 0, 2047, 2047, 0, -32, 16'hffff, 1, '0, 1);
		add_row(-5, 3, 10, 3, 100, 3, 3, -10, 16'h1234, 1, '0, 1);
		add_row(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 16'h8000, 1, '0, 1);
		add_row(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, 16'h7fff, 1, '0, 1);
		// largest triangles, both windings, whole span on an edge
		add_row(-2048, -2048, 2047, -2048, -2048, 2047, -2048, -2048, 16'ha5a5, 1, '1, 0);
		add_row(-2048, -2048, -2048, 2047, 2047, -2048, -2048, -2048, 16'h5a5a, 1, '1, 0);
		add_row(2047, 2047, -2048, 2047, 2047, -2048, 2047, 1984, 16'hf800, 1, '1, 0);
		// span far from the triangle
		add_row(0, 0, 10, 0, 0, 10, 2047, 2047, 16'h07e0, 1, '0, 0);
		// span runs past the top of the range: pixels must not wrap to the left side
		add_row(-2048, 0, -1980, 0, -2048, 60, 0, 2040, 16'h001f, 1, '0, 0);
		// apex exactly on one pixel
		add_row(10, 10, 30, 10, 10, 30, 30, 0, 16'hbeef, 1, 64'h400, 0);
		add_row(5, 0, 20, 0, 5, 15, 5, 0, 16'h0001, 0, '0, 0);
		add_row(5, 0, 5, 15, 20, 0, 5, 0, 16'h0002, 0, '0, 0);
		add_row(-100, -50, -40, -50, -70, -10, -30, -100, 16'h4321, 0, '0, 0);
		add_row(0, 0, 63, 1, 0, 1, 1, 0, 16'hc3c3, 0, '0, 0);
		add_row(0, 0, 60, 0, 30, 40, 41, 0, 16'h3c3c, 0, '0, 0);
		add_row(0, 0, 60, 0, 30, 40, 40, 0, 16'h0f0f, 0, '0, 0);
		add_row(32, -100, 200, 100, 32, 100, 0, 0, 16'hf0f0, 0, '0, 0);
		add_row(-2048, 2047, 2047, 0, -2048, -2048, 0, -2048, 16'h9999, 0, '0, 0);
		add_row(2047, -2048, -2048, 1000, 1500, 2047, 100, 1000, 16'h6666, 0, '0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (span_table[n]) begin
			maybe_gap(1'b1);
			if (span_table[n].known) begin
				want.out_row_y     = span_table[n].stim.row_y;
				want.out_span_x    = span_table[n].stim.span_x;
				want.coverage_mask = span_table[n].mask;
				want.out_color     = span_table[n].stim.pixel_color;
				want.zero_area     = span_table[n].zero;
			end else begin
				want = span_coverage(span_table[n].stim);
			end
			send_span(span_table[n].stim, want);
		end

		for (int n = 0; n < RANDOM_SPANS; n++) begin
			if (n == 600) begin
				// back up the pipeline: hold results while items keep coming
				long_hold_req = 1'b1;
				no_gap_left = 40;
			end
			if (n == 1000) begin
				item_valid <= 1'b0;
				while (pending_spans.size() != 0)
					@(posedge clk);
			end
			quiet = (n >= RANDOM_SPANS - 200);
			maybe_gap(no_gap_left == 0);
			if (no_gap_left > 0)
				no_gap_left--;
			it = random_span();
			send_span(it, span_coverage(it));
		end
		item_valid <= 1'b0;

		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d spans, %0d results back: %0d covered, %0d fully covered, %0d degenerate.",
			spans_sent, spans_returned, covered_spans, full_spans, degenerate_spans);
		$display("Input and output stalls, one long output hold-off and a full drain were exercised.");
		if (mismatches == 0 && pending_spans.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### triangle_span_coverage_unit.f
+incdir+rtl/core
rtl/core/tsc_pkg.sv
rtl/core/tsc_front.sv
rtl/core/tsc_lane.sv
rtl/core/tsc_merge.sv
rtl/core/triangle_span_coverage_unit.sv
rtl/core/tsc_checker.sv
test/tb_top.sv
